// ----- rtl/medf_pkg.sv -----
package medf_pkg;

	// Event classes and codes.
	localparam logic [15:0] EV_SYN      = 16'h0000;
	localparam logic [15:0] EV_KEY      = 16'h0001;
	localparam logic [15:0] EV_REL      = 16'h0002;
	localparam logic [15:0] CODE_REPORT = 16'h0000;
	localparam logic [15:0] REL_X       = 16'h0000;
	localparam logic [15:0] REL_Y       = 16'h0001;
	localparam logic [15:0] CODE_WHEEL  = 16'h0008;
	localparam logic [15:0] REL_HWHEEL  = 16'h000B;
	localparam logic [15:0] BTN_BASE    = 16'h0110;

	// Configuration port layout and register indexes.
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IDLE       = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK_FIX  = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCROLL_FIX = 8'd3;

	// Register reset values.
	localparam logic [19:0] DEBOUNCE_RST = 20'd15000;
	localparam logic [23:0] IDLE_RST     = 24'd300000;

	// Wheel direction coding.
	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	// One stored event of a batch.
	typedef struct packed {
		logic [15:0] ev_type;
		logic [15:0] ev_code;
		logic [31:0] ev_value;
		logic [47:0] ev_time;
	} entry_t;

	// Flush command from the front to the back.
	typedef struct packed {
		logic bank;
		logic force_fix;
		logic dir_up;
	} cmd_t;

	// Bank release from the back to the front.
	typedef struct packed {
		logic valid;
		logic bank;
	} rel_t;

	function automatic logic is_wheel(input logic [15:0] t, input logic [15:0] c);
		return (t == EV_REL) && ((c == CODE_WHEEL) || (c == REL_HWHEEL));
	endfunction

	function automatic logic is_report(input logic [15:0] t, input logic [15:0] c);
		return (t == EV_SYN) && (c == CODE_REPORT);
	endfunction

endpackage

// ----- rtl/medf_if.sv -----
// Input event channel.
interface medf_evt_if;
	logic               valid;
	logic               ready;
	logic        [15:0] event_type;
	logic        [15:0] event_code;
	logic signed [31:0] event_value;
	logic        [47:0] event_time_us;

	modport source(output valid, event_type, event_code, event_value, event_time_us,
		input ready);
	modport sink(input valid, event_type, event_code, event_value, event_time_us,
		output ready);
endinterface

// Result event channel.
interface medf_res_if;
	logic               valid;
	logic               ready;
	logic        [15:0] out_type;
	logic        [15:0] out_code;
	logic signed [31:0] out_value;
	logic        [47:0] out_time_us;
	logic               last_of_batch;

	modport source(output valid, out_type, out_code, out_value, out_time_us, last_of_batch,
		input ready);
	modport sink(input valid, out_type, out_code, out_value, out_time_us, last_of_batch,
		output ready);
endinterface

// Configuration write channel.
interface medf_cfg_if import medf_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/medf_ram.sv -----
module medf_ram #(
	parameter int WIDTH = 112,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ----- rtl/medf_front.sv -----
module medf_front import medf_pkg::*; #(
	parameter int BATCH_DEPTH = 64,
	parameter int NUM_BUTTONS = 7
) (
	input  logic                           clk,
	input  logic                           arst_n,
	medf_evt_if.sink                       evt,
	medf_cfg_if.sink                       cfg,
	output logic                           wr_en,
	output logic [$clog2(BATCH_DEPTH):0]   wr_addr,
	output entry_t                         wr_data,
	output logic                           cmd_push,
	output cmd_t                           cmd,
	input  rel_t                           rel
);

	localparam int AW = $clog2(BATCH_DEPTH);
	localparam int CW = $clog2(BATCH_DEPTH + 1);
	localparam int BW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

	// Captured input event.
	logic        valid_s1;
	logic [15:0] type_s1;
	logic [15:0] code_s1;
	logic [31:0] value_s1;
	logic [47:0] time_s1;

	// Configuration registers.
	logic [19:0] debounce_q;
	logic [23:0] idle_q;
	logic        click_q;
	logic        scroll_q;

	// Button debounce state.
	logic [NUM_BUTTONS-1:0] ign_press_q;
	logic [NUM_BUTTONS-1:0] ign_rls_q;
	logic [47:0]            press_time_q [NUM_BUTTONS];
	logic [47:0]            rls_time_q   [NUM_BUTTONS];

	// Batch and wheel filter state.
	logic [CW-1:0] count_q;
	logic          wbank_q;
	logic [1:0]    busy_q;
	logic [1:0]    busy_n;
	logic          wheel_seen_q;
	logic          wheel_up_q;
	logic [47:0]   wheel_time_q;
	logic [47:0]   prev_time_q;
	dir_t          valid_dir_q;
	dir_t          pending_dir_q;
	logic [1:0]    rev_cnt_q;

	logic          accept;
	logic          is_btn, is_rel, is_whl, is_sync, is_rep;
	logic          is_press, is_rls;
	logic [15:0]   btn_off;
	logic [BW-1:0] b;
	logic [47:0]   then_t;
	logic [48:0]   diff;
	logic          in_win, dbg, discard, store, flush;
	logic [CW-1:0] count_inc;
	logic          filt_on, timeout;
	logic [48:0]   pdiff;
	dir_t          dir_now, vd0, pd0, vd_n, pd_n;
	logic [1:0]    rc0, rc_try, rc_n;
	logic          force_fix;

	// A new event is taken once the previous one is classified and the bank is free.
	assign evt.ready = !valid_s1 && !busy_q[wbank_q];
	assign accept    = evt.valid && evt.ready;
	assign cfg.ready = 1'b1;

	// Classify the captured event.
	assign is_btn  = (type_s1 == EV_KEY) && (code_s1 >= BTN_BASE) &&
		({1'b0, code_s1} < (17'(BTN_BASE) + 17'(NUM_BUTTONS)));
	assign is_rel  = (type_s1 == EV_REL) && ((code_s1 == REL_X) || (code_s1 == REL_Y) ||
		(code_s1 == CODE_WHEEL) || (code_s1 == REL_HWHEEL));
	assign is_whl  = is_wheel(type_s1, code_s1);
	assign is_sync = (type_s1 == EV_SYN);
	assign is_rep  = is_report(type_s1, code_s1);
	assign is_press = (value_s1 == 32'd1);
	assign is_rls   = (value_s1 == 32'd0);
	assign btn_off  = code_s1 - BTN_BASE;
	assign b        = btn_off[BW-1:0];

	// Time since the opposite stable edge; a backward time counts as inside the window.
	assign then_t = is_press ? rls_time_q[b] : press_time_q[b];
	assign diff   = {1'b0, time_s1} - {1'b0, then_t};
	assign in_win = diff[48] || (diff[47:0] < {28'd0, debounce_q});
	assign dbg    = valid_s1 && click_q && is_btn;
	assign discard = dbg && ((is_press && (ign_press_q[b] || in_win)) ||
		(is_rls && (ign_rls_q[b] || in_win)));

	// Buffer write.
	assign store     = valid_s1 && !discard && (is_btn || is_rel || is_sync) &&
		(count_q < CW'(BATCH_DEPTH));
	assign count_inc = count_q + CW'(store);
	assign wr_en     = store;
	assign wr_addr   = {wbank_q, count_q[AW-1:0]};
	assign wr_data   = '{ev_type: type_s1, ev_code: code_s1, ev_value: value_s1,
		ev_time: time_s1};
	assign flush     = valid_s1 && is_rep;

	// Wheel direction filter, evaluated on a sync report.
	assign filt_on = scroll_q && wheel_seen_q;
	assign dir_now = wheel_up_q ? DIR_UP : DIR_DOWN;
	assign pdiff   = {1'b0, wheel_time_q} - {1'b0, prev_time_q};
	assign timeout = (prev_time_q != 48'd0) && !pdiff[48] && (pdiff[47:0] > {24'd0, idle_q});

	always_comb begin
		vd0 = timeout ? DIR_NONE : valid_dir_q;
		pd0 = timeout ? DIR_NONE : pending_dir_q;
		rc0 = timeout ? 2'd0 : rev_cnt_q;
		vd_n = vd0;
		pd_n = pd0;
		rc_n = rc0;
		rc_try = 2'd1;
		force_fix = 1'b0;
		if (vd0 == DIR_NONE) begin
			vd_n = dir_now;
		end else if (dir_now == vd0) begin
			rc_n = 2'd0;
		end else begin
			rc_try = (dir_now == pd0) ? rc0 + 2'd1 : 2'd1;
			pd_n = dir_now;
			if (rc_try >= 2'd2) begin
				vd_n = dir_now;
				rc_n = 2'd0;
			end else begin
				rc_n = rc_try;
				force_fix = 1'b1;
			end
		end
		if (!filt_on) begin
			force_fix = 1'b0;
		end
	end

	assign cmd_push = flush;
	assign cmd = '{bank: wbank_q, force_fix: force_fix, dir_up: (vd_n == DIR_UP)};

	// Bank ownership: set on flush, cleared when the back has drained it.
	always_comb begin
		busy_n = busy_q;
		if (rel.valid) begin
			busy_n[rel.bank] = 1'b0;
		end
		if (flush) begin
			busy_n[wbank_q] = 1'b1;
		end
	end

	// Input capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			type_s1  <= evt.event_type;
			code_s1  <= evt.event_code;
			value_s1 <= evt.event_value;
			time_s1  <= evt.event_time_us;
		end
	end

	// Control and filter state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1      <= 1'b0;
			debounce_q    <= DEBOUNCE_RST;
			idle_q        <= IDLE_RST;
			click_q       <= 1'b1;
			scroll_q      <= 1'b1;
			ign_press_q   <= '0;
			ign_rls_q     <= '0;
			for (int i = 0; i < NUM_BUTTONS; i++) begin
				press_time_q[i] <= 48'd0;
				rls_time_q[i]   <= 48'd0;
			end
			count_q       <= '0;
			wbank_q       <= 1'b0;
			busy_q        <= 2'b00;
			wheel_seen_q  <= 1'b0;
			wheel_up_q    <= 1'b0;
			wheel_time_q  <= 48'd0;
			prev_time_q   <= 48'd0;
			valid_dir_q   <= DIR_NONE;
			pending_dir_q <= DIR_NONE;
			rev_cnt_q     <= 2'd0;
		end else begin
			valid_s1 <= accept;
			busy_q   <= busy_n;

			if (cfg.valid) begin
				unique case (cfg.index)
					REG_DEBOUNCE:   debounce_q <= cfg.data[19:0];
					REG_IDLE:       idle_q     <= cfg.data[23:0];
					REG_CLICK_FIX:  click_q    <= cfg.data[0];
					REG_SCROLL_FIX: scroll_q   <= cfg.data[0];
					default: ;
				endcase
			end

			// Debounce bookkeeping for one button.
			if (dbg && is_press) begin
				if (ign_press_q[b]) begin
					ign_press_q[b] <= 1'b0;
				end else if (in_win) begin
					ign_rls_q[b] <= 1'b1;
				end else begin
					press_time_q[b] <= time_s1;
				end
			end else if (dbg && is_rls) begin
				if (ign_rls_q[b]) begin
					ign_rls_q[b] <= 1'b0;
				end else if (in_win) begin
					ign_press_q[b] <= 1'b1;
				end else begin
					rls_time_q[b] <= time_s1;
				end
			end

			// Last wheel event of the batch.
			if (valid_s1 && is_whl) begin
				wheel_seen_q <= 1'b1;
				wheel_up_q   <= !value_s1[31] && (value_s1 != 32'd0);
				wheel_time_q <= time_s1;
			end

			// Flush hands the bank to the back; a full batch is dropped.
			if (flush) begin
				count_q      <= '0;
				wheel_seen_q <= 1'b0;
				wbank_q      <= !wbank_q;
				if (filt_on) begin
					prev_time_q   <= wheel_time_q;
					valid_dir_q   <= vd_n;
					pending_dir_q <= pd_n;
					rev_cnt_q     <= rc_n;
				end
			end else if (count_inc >= CW'(BATCH_DEPTH)) begin
				count_q <= '0;
			end else begin
				count_q <= count_inc;
			end
		end
	end

`ifndef SYNTH
	// The fill count never rests at or above the batch depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CW'(BATCH_DEPTH))
		else $error("batch count out of range");

	// A flush never hands over a bank that the back still owns.
	a_flush_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !busy_q[wbank_q])
		else $error("flush into busy bank");
`endif

endmodule

// ----- rtl/medf_queue.sv -----
module medf_queue import medf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_data,
	input  logic pop,
	output logic not_empty,
	output cmd_t pop_data
);

	cmd_t       entry_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign not_empty = (cnt_q != 2'd0);
	assign pop_data  = entry_q[rptr_q];

	// Command storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wptr_q] <= push_data;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= !wptr_q;
			end
			if (pop) begin
				rptr_q <= !rptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTH
	// Two banks bound the number of pending flushes.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q != 2'd2) || pop)
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != 2'd0))
		else $error("command queue underflow");
`endif

endmodule

// ----- rtl/medf_back.sv -----
module medf_back import medf_pkg::*; #(
	parameter int BATCH_DEPTH = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_valid,
	input  cmd_t                         q_data,
	output logic                         q_pop,
	output logic                         rd_en,
	output logic [$clog2(BATCH_DEPTH):0] rd_addr,
	input  entry_t                       rd_data,
	output rel_t                         rel,
	medf_res_if.source                   res
);

	localparam int AW = $clog2(BATCH_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RD,
		ST_DATA
	} state_t;

	state_t        state_q;
	cmd_t          cmd_q;
	logic [AW-1:0] idx_q;
	logic          out_valid_q;
	logic [15:0]   out_type_q;
	logic [15:0]   out_code_q;
	logic [31:0]   out_value_q;
	logic [47:0]   out_time_q;
	logic          out_last_q;
	rel_t          rel_q;

	logic        can_load;
	logic        load;
	logic        last;
	logic [31:0] v, neg, fixed;
	logic        is_min;

	assign q_pop   = (state_q == ST_IDLE) && q_valid;
	assign rd_en   = (state_q == ST_RD);
	assign rd_addr = {cmd_q.bank, idx_q};
	assign can_load = !out_valid_q || res.ready;
	assign load     = (state_q == ST_DATA) && can_load;
	assign last     = is_report(rd_data.ev_type, rd_data.ev_code);

	// Wheel sign correction toward the valid direction.
	assign v      = rd_data.ev_value;
	assign neg    = 32'd0 - v;
	assign is_min = (v == 32'h8000_0000);

	always_comb begin
		fixed = v;
		if (cmd_q.force_fix && is_wheel(rd_data.ev_type, rd_data.ev_code)) begin
			if (cmd_q.dir_up) begin
				fixed = v[31] ? (is_min ? 32'h7FFF_FFFF : neg) : v;
			end else begin
				fixed = v[31] ? (is_min ? 32'h8000_0001 : v) : neg;
			end
		end
	end

	assign res.valid         = out_valid_q;
	assign res.out_type      = out_type_q;
	assign res.out_code      = out_code_q;
	assign res.out_value     = out_value_q;
	assign res.out_time_us   = out_time_q;
	assign res.last_of_batch = out_last_q;
	assign rel               = rel_q;

	// Drain sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_type_q  <= '0;
			out_code_q  <= '0;
			out_value_q <= '0;
			out_time_q  <= '0;
			out_last_q  <= 1'b0;
			rel_q       <= '0;
		end else begin
			// The bank goes back to the front once its report is loaded.
			rel_q <= '{valid: load && last, bank: cmd_q.bank};
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cmd_q   <= q_data;
						idx_q   <= '0;
						state_q <= ST_RD;
					end
				end
				ST_RD: begin
					state_q <= ST_DATA;
				end
				ST_DATA: begin
					if (can_load) begin
						out_type_q  <= rd_data.ev_type;
						out_code_q  <= rd_data.ev_code;
						out_value_q <= fixed;
						out_time_q  <= rd_data.ev_time;
						out_last_q  <= last;
						if (last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + AW'(1);
							state_q <= ST_RD;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	// A bank is released together with the sync report that closes its batch.
	a_release_last: assert property (@(posedge clk) disable iff (!arst_n)
		rel_q.valid |-> out_valid_q && out_last_q && (out_type_q == EV_SYN) &&
		(out_code_q == CODE_REPORT))
		else $error("bank released before end of batch");
`endif

endmodule

// ----- rtl/mouse_event_debounce_filter.sv -----
// Channel  Role    Request moved
// -------  ------  ----------------------------------------------------------
// evt      sink    one timestamped input event (type, code, value, time)
// res      source  one forwarded event of a flushed batch, with last flag
// cfg      sink    one register write (index, data), always ready
//
// The front captures, then classifies and buffers each event before taking the next one.
// For each result the back reads the buffer RAM and then loads the output register,
// after taking the batch's flush command; a load waits while the output is stalled.
// Reset clears the button tables, the wheel filter and the counters at once; the buffer
// RAM is not cleared since no entry is read before it is written.
// A stalled result holds only the back; the front fills the other bank and then waits.
module mouse_event_debounce_filter import medf_pkg::*; #(
	parameter int BATCH_DEPTH = 64,
	parameter int NUM_BUTTONS = 7
) (
	input  logic       clk,
	input  logic       arst_n,
	medf_evt_if.sink   evt,
	medf_res_if.source res,
	medf_cfg_if.sink   cfg
);

	localparam int AW        = $clog2(BATCH_DEPTH);
	localparam int RAM_DEPTH = 2 * (1 << AW);

	logic          wr_en;
	logic [AW:0]   wr_addr;
	entry_t        wr_data;
	logic          rd_en;
	logic [AW:0]   rd_addr;
	entry_t        rd_data;
	logic          cmd_push;
	cmd_t          cmd;
	logic          q_valid;
	logic          q_pop;
	cmd_t          q_data;
	rel_t          rel;

	// Front: debounce, classification and batch buffering.
	medf_front #(
		.BATCH_DEPTH(BATCH_DEPTH),
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.evt      (evt),
		.cfg      (cfg),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.cmd_push (cmd_push),
		.cmd      (cmd),
		.rel      (rel)
	);

	// Pending flush commands.
	medf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cmd_push),
		.push_data (cmd),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_data)
	);

	// Two-bank batch buffer.
	medf_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Back: batch drain with wheel sign correction.
	medf_back #(
		.BATCH_DEPTH(BATCH_DEPTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_data),
		.q_pop   (q_pop),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.rel     (rel),
		.res     (res)
	);

endmodule
